### src/kle_pkg.sv
`default_nettype none

package kle_pkg;

	localparam int KNOBS  = 2;
	localparam int KW     = $clog2(KNOBS);
	localparam int LEDS   = 8;
	localparam int PIXELS = 22;

	typedef logic [10:0] pos_t;     // Q3.8 ring position, 0..1792
	typedef logic [8:0]  bright_t;  // Q1.8 brightness, 0..256

	localparam pos_t           RING_MAX    = 11'd1792;
	localparam bright_t        FULL_BRIGHT = 9'd256;
	localparam logic [4:0]     LAST_SLOT   = 5'(PIXELS - 1);

	// colour weights, spot 0 and spot 1
	localparam logic [8:0] W0_RED = 9'd70;
	localparam logic [8:0] W1_RED = 9'd250;
	localparam logic [8:0] W0_GRN = 9'd230;
	localparam logic [8:0] W1_GRN = 9'd60;
	localparam logic [8:0] W0_BLU = 9'd250;
	localparam logic [8:0] W1_BLU = 9'd200;

	typedef struct packed {
		logic [15:0] knob0_count;
		logic [15:0] knob1_count;
		logic [8:0]  buttons;
	} tick_t;

	typedef struct packed {
		logic [4:0] chain_slot;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_pixel;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	localparam rgb_t OVR_LIT  = '{red: 8'd62,  green: 8'd100, blue: 8'd0};
	localparam rgb_t OVR_WARN = '{red: 8'd255, green: 8'd15,  blue: 8'd15};

	typedef enum logic [2:0] {
		REG_KNOB_REVERSE   = 3'd0,
		REG_COUNT_WEIGHT   = 3'd1,
		REG_VEL_CLAMP      = 3'd2,
		REG_MOVE_THRESHOLD = 3'd3,
		REG_VEL_DECAY      = 3'd4,
		REG_MOVE_STEP      = 3'd5,
		REG_FADE_TICKS     = 3'd6,
		REG_FADE_STEP      = 3'd7
	} cfg_reg_e;

	typedef struct packed {
		logic        write;
		logic [2:0]  index;
		logic [16:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic          capture;
		logic          delta;
		logic          vel;
		logic          move;
		logic [KW-1:0] knob;
		logic          led_go;
		logic [2:0]    led;
		logic          emit;
		logic [4:0]    slot;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} ctrl_sts_t;

	typedef struct packed {
		logic       used;
		logic [3:0] btn;
		logic       warn;
	} ovr_t;

	function automatic pos_t start_pos(input int k);
		return (k == 0) ? '0 : RING_MAX;
	endfunction

	// ring LED shown at each chain slot
	function automatic logic [2:0] slot_led(input logic [4:0] slot);
		logic [2:0] led;
		case (slot)
			5'd8:    led = 3'd5;
			5'd9:    led = 3'd4;
			5'd10:   led = 3'd3;
			5'd11:   led = 3'd2;
			5'd12:   led = 3'd1;
			5'd13:   led = 3'd0;
			5'd14:   led = 3'd2;
			5'd15:   led = 3'd3;
			5'd16:   led = 3'd4;
			5'd17:   led = 3'd5;
			5'd18:   led = 3'd6;
			5'd19:   led = 3'd7;
			5'd20:   led = 3'd4;
			5'd21:   led = 3'd3;
			default: led = slot[2:0];
		endcase
		return led;
	endfunction

	// button, if any, that overrides each chain slot
	function automatic ovr_t slot_ovr(input logic [4:0] slot);
		ovr_t o;
		o = '{used: 1'b0, btn: 4'd0, warn: 1'b0};
		case (slot)
			5'd0, 5'd1:   o = '{used: 1'b1, btn: 4'd4, warn: 1'b0};
			5'd2, 5'd3:   o = '{used: 1'b1, btn: 4'd2, warn: 1'b0};
			5'd4, 5'd5:   o = '{used: 1'b1, btn: 4'd1, warn: 1'b0};
			5'd6, 5'd7:   o = '{used: 1'b1, btn: 4'd0, warn: 1'b0};
			5'd8, 5'd9:   o = '{used: 1'b1, btn: 4'd5, warn: 1'b1};
			5'd12, 5'd13: o = '{used: 1'b1, btn: 4'd3, warn: 1'b1};
			default:      o = '{used: 1'b0, btn: 4'd0, warn: 1'b0};
		endcase
		return o;
	endfunction

endpackage

`default_nettype wire

### src/kle_ctrl.sv
`default_nettype none

module kle_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 tick_valid,
	output logic                      tick_stall,
	input  wire kle_pkg::ctrl_sts_t   sts,
	output kle_pkg::ctrl_cmd_t        cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DELTA = 6'b000010,
		ST_VEL   = 6'b000100,
		ST_MOVE  = 6'b001000,
		ST_LED   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	localparam logic [3:0]          LED_END  = 4'(kle_pkg::LEDS);
	localparam logic [kle_pkg::KW-1:0] KNOB_END = kle_pkg::KW'(kle_pkg::KNOBS - 1);

	state_t                     state_q, state_d;
	logic [kle_pkg::KW-1:0]     knob_q, knob_d;
	logic [3:0]                 led_q, led_d;
	logic [4:0]                 slot_q, slot_d;

	always_comb begin
		state_d    = state_q;
		knob_d     = knob_q;
		led_d      = led_q;
		slot_d     = slot_q;
		tick_stall = 1'b1;
		cmd        = '0;
		cmd.knob   = knob_q;
		cmd.led    = led_q[2:0];
		cmd.slot   = slot_q;
		case (state_q)
			ST_IDLE: begin
				tick_stall = 1'b0;
				if (tick_valid) begin
					cmd.capture = 1'b1;
					knob_d      = '0;
					state_d     = ST_DELTA;
				end
			end
			ST_DELTA: begin
				cmd.delta = 1'b1;
				state_d   = ST_VEL;
			end
			ST_VEL: begin
				cmd.vel = 1'b1;
				state_d = ST_MOVE;
			end
			ST_MOVE: begin
				cmd.move = 1'b1;
				if (knob_q == KNOB_END) begin
					led_d   = '0;
					state_d = ST_LED;
				end else begin
					knob_d  = knob_q + 1'b1;
					state_d = ST_DELTA;
				end
			end
			ST_LED: begin
				// a final pass at LED_END issues no led_go and drains the colour pipeline
				if (led_q == LED_END) begin
					slot_d  = '0;
					state_d = ST_EMIT;
				end else begin
					cmd.led_go = 1'b1;
					led_d      = led_q + 4'd1;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (slot_q == kle_pkg::LAST_SLOT) begin
						state_d = ST_IDLE;
					end else begin
						slot_d = slot_q + 5'd1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			knob_q  <= '0;
			led_q   <= '0;
			slot_q  <= '0;
		end else begin
			state_q <= state_d;
			knob_q  <= knob_d;
			led_q   <= led_d;
			slot_q  <= slot_d;
		end
	end

endmodule

`default_nettype wire

### src/kle_knob.sv
`default_nettype none

module kle_knob (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire kle_pkg::cfg_wr_t     cfg,
	input  wire kle_pkg::ctrl_cmd_t   cmd,
	input  wire kle_pkg::tick_t       tick,
	output kle_pkg::pos_t             pos    [kle_pkg::KNOBS],
	output kle_pkg::bright_t          bright [kle_pkg::KNOBS]
);

	// configuration
	logic [1:0]  rev_q;
	logic [11:0] weight_q;
	logic [16:0] clamp_q;
	logic [16:0] thr_q;
	logic [16:0] decay_q;
	logic [10:0] step_q;
	logic [7:0]  fade_ticks_q;
	logic [8:0]  fade_step_q;

	// knob state
	logic [15:0]              prev_q   [kle_pkg::KNOBS];
	logic signed [17:0]       vel_q    [kle_pkg::KNOBS];
	kle_pkg::pos_t            pos_q    [kle_pkg::KNOBS];
	kle_pkg::bright_t         bright_q [kle_pkg::KNOBS];
	logic [7:0]               idle_q   [kle_pkg::KNOBS];

	logic [15:0]              cnt_q    [kle_pkg::KNOBS];
	logic signed [29:0]       prod_s1;
	logic signed [17:0]       vel_s2;

	logic [kle_pkg::KW-1:0]   k;
	logic [15:0]              raw;
	logic signed [16:0]       dlt_raw, dlt;
	logic signed [29:0]       prod;
	logic signed [30:0]       sum, lim;
	logic signed [17:0]       vel_clamped;

	logic signed [17:0]       thr, dec;
	logic                     mv_neg, mv_pos;
	kle_pkg::pos_t            step;
	logic signed [12:0]       p_cur, p_mv, p_w;
	logic [7:0]               idle_inc, idle_nxt;
	logic signed [10:0]       b_diff;
	kle_pkg::bright_t         bright_nxt;
	logic signed [17:0]       vel_dec;

	assign k = cmd.knob;

	// delta and weighted count
	always_comb begin
		raw     = cnt_q[k] - prev_q[k];
		dlt_raw = {raw[15], raw};
		dlt     = rev_q[k] ? dlt_raw : -dlt_raw;
		prod    = 30'(dlt) * 30'(signed'({1'b0, weight_q}));
	end

	// accumulate and clamp
	always_comb begin
		sum = 31'(vel_q[k]) + 31'(prod_s1);
		lim = 31'(signed'({1'b0, clamp_q}));
		if (sum > lim) begin
			vel_clamped = 18'(lim);
		end else if (sum < -lim) begin
			vel_clamped = 18'(-lim);
		end else begin
			vel_clamped = 18'(sum);
		end
	end

	// move, fade, wrap, decay
	always_comb begin
		thr        = signed'({1'b0, thr_q});
		dec        = signed'({1'b0, decay_q});
		mv_neg     = vel_s2 < -thr;
		mv_pos     = vel_s2 > thr;
		step       = (step_q > kle_pkg::RING_MAX) ? kle_pkg::RING_MAX : step_q;
		p_cur      = signed'({2'b00, pos_q[k]});
		idle_inc   = (idle_q[k] == 8'hFF) ? 8'hFF : idle_q[k] + 8'd1;
		b_diff     = signed'({2'b00, bright_q[k]}) - signed'({2'b00, fade_step_q});
		p_mv       = p_cur;
		idle_nxt   = idle_inc;
		bright_nxt = bright_q[k];
		if (mv_neg || mv_pos) begin
			idle_nxt   = '0;
			bright_nxt = kle_pkg::FULL_BRIGHT;
			p_mv       = mv_neg ? p_cur - signed'({2'b00, step})
			                    : p_cur + signed'({2'b00, step});
		end else if (idle_inc > fade_ticks_q) begin
			p_mv = signed'({2'b00, kle_pkg::start_pos(int'(k))});
		end else begin
			bright_nxt = (b_diff < 0) ? '0 : b_diff[8:0];
		end
		p_w = p_mv;
		if (p_mv < 0) begin
			p_w = p_mv + signed'({2'b00, kle_pkg::RING_MAX});
		end else if (p_mv > signed'({2'b00, kle_pkg::RING_MAX})) begin
			p_w = p_mv - signed'({2'b00, kle_pkg::RING_MAX});
		end
		if (vel_s2 < -dec) begin
			vel_dec = vel_s2 + dec;
		end else if (vel_s2 > dec) begin
			vel_dec = vel_s2 - dec;
		end else begin
			vel_dec = vel_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cnt_q[0] <= tick.knob0_count;
			cnt_q[1] <= tick.knob1_count;
		end
		if (cmd.delta) begin
			prod_s1 <= prod;
		end
		if (cmd.vel) begin
			vel_s2 <= vel_clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_q        <= 2'd0;
			weight_q     <= 12'd437;
			clamp_q      <= 17'd104858;
			thr_q        <= 17'd52429;
			decay_q      <= 17'd4928;
			step_q       <= 11'd128;
			fade_ticks_q <= 8'd5;
			fade_step_q  <= 9'd51;
		end else if (cfg.write) begin
			case (kle_pkg::cfg_reg_e'(cfg.index))
				kle_pkg::REG_KNOB_REVERSE:   rev_q        <= cfg.data[1:0];
				kle_pkg::REG_COUNT_WEIGHT:   weight_q     <= cfg.data[11:0];
				kle_pkg::REG_VEL_CLAMP:      clamp_q      <= cfg.data;
				kle_pkg::REG_MOVE_THRESHOLD: thr_q        <= cfg.data;
				kle_pkg::REG_VEL_DECAY:      decay_q      <= cfg.data;
				kle_pkg::REG_MOVE_STEP:      step_q       <= cfg.data[10:0];
				kle_pkg::REG_FADE_TICKS:     fade_ticks_q <= cfg.data[7:0];
				kle_pkg::REG_FADE_STEP:      fade_step_q  <= cfg.data[8:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < kle_pkg::KNOBS; i++) begin
				prev_q[i]   <= '0;
				vel_q[i]    <= '0;
				pos_q[i]    <= kle_pkg::start_pos(i);
				bright_q[i] <= '0;
				idle_q[i]   <= '0;
			end
		end else begin
			if (cmd.delta) begin
				prev_q[k] <= cnt_q[k];
			end
			if (cmd.move) begin
				vel_q[k]    <= vel_dec;
				pos_q[k]    <= p_w[10:0];
				bright_q[k] <= bright_nxt;
				idle_q[k]   <= idle_nxt;
			end
		end
	end

	assign pos    = pos_q;
	assign bright = bright_q;

endmodule

`default_nettype wire

### src/kle_pixel.sv
`default_nettype none

module kle_pixel (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire kle_pkg::ctrl_cmd_t   cmd,
	input  wire kle_pkg::tick_t       tick,
	input  wire kle_pkg::pos_t        pos    [kle_pkg::KNOBS],
	input  wire kle_pkg::bright_t     bright [kle_pkg::KNOBS],
	output kle_pkg::ctrl_sts_t        sts,
	output logic                      pix_valid,
	input  wire logic                 pix_stall,
	output kle_pkg::pixel_t           pix
);

	function automatic logic [7:0] mix(input logic [17:0] s0, input logic [17:0] s1,
	                                   input logic [8:0] w0, input logic [8:0] w1);
		logic [27:0] acc;
		logic [10:0] c;
		acc = 28'(s0) * 28'(w0) + 28'(s1) * 28'(w1);
		c   = acc[27:17];
		return (c > 11'd255) ? 8'd255 : c[7:0];
	endfunction

	logic [8:0]           btn_q;
	logic [17:0]          strength_s1 [kle_pkg::KNOBS];
	logic [2:0]           led_s1;
	logic                 go_s1;
	kle_pkg::rgb_t        col_q [kle_pkg::LEDS];
	kle_pkg::pixel_t      out_q;
	logic                 vld_q;

	logic signed [12:0]   offset [kle_pkg::KNOBS];
	logic [11:0]          offset_abs [kle_pkg::KNOBS];
	logic [9:0]           near [kle_pkg::KNOBS];
	logic [17:0]          strength [kle_pkg::KNOBS];

	logic [2:0]           emit_led;
	kle_pkg::ovr_t        emit_ovr;
	kle_pkg::rgb_t        emit_col;

	// triangular spot strength for the LED being worked on
	always_comb begin
		for (int j = 0; j < kle_pkg::KNOBS; j++) begin
			offset[j]     = signed'({2'b00, pos[j]}) - signed'({2'b00, cmd.led, 8'd0});
			offset_abs[j] = (offset[j] < 0) ? 12'(-offset[j]) : 12'(offset[j]);
			near[j]       = (offset_abs[j] > 12'd512) ? 10'd0 : 10'(12'd512 - offset_abs[j]);
			strength[j]   = 18'(19'(near[j]) * 19'(bright[j]));
		end
	end

	always_comb begin
		emit_led = kle_pkg::slot_led(cmd.slot);
		emit_ovr = kle_pkg::slot_ovr(cmd.slot);
		emit_col = col_q[emit_led];
		if (emit_ovr.used && btn_q[emit_ovr.btn]) begin
			emit_col = emit_ovr.warn ? kle_pkg::OVR_WARN : kle_pkg::OVR_LIT;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			btn_q <= tick.buttons;
		end
		if (cmd.led_go) begin
			strength_s1 <= strength;
			led_s1      <= cmd.led;
		end
		if (go_s1) begin
			col_q[led_s1] <= '{
				red:   mix(strength_s1[0], strength_s1[1], kle_pkg::W0_RED, kle_pkg::W1_RED),
				green: mix(strength_s1[0], strength_s1[1], kle_pkg::W0_GRN, kle_pkg::W1_GRN),
				blue:  mix(strength_s1[0], strength_s1[1], kle_pkg::W0_BLU, kle_pkg::W1_BLU)
			};
		end
		if (cmd.emit) begin
			out_q.chain_slot <= cmd.slot;
			out_q.red        <= emit_col.red;
			out_q.green      <= emit_col.green;
			out_q.blue       <= emit_col.blue;
			out_q.last_pixel <= (cmd.slot == kle_pkg::LAST_SLOT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
			vld_q <= 1'b0;
		end else begin
			go_s1 <= cmd.led_go;
			if (cmd.emit) begin
				vld_q <= 1'b1;
			end else if (!pix_stall) begin
				vld_q <= 1'b0;
			end
		end
	end

	assign sts.out_free = !vld_q || !pix_stall;
	assign pix_valid    = vld_q;
	assign pix          = out_q;

endmodule

`default_nettype wire

### src/knob_led_chase_effect.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// tick      in         tick_valid/stall     kle_pkg::tick_t  (knob counts, buttons)
// pix       out        pix_valid/stall      kle_pkg::pixel_t (slot, r, g, b, last)
// cfg       in         cfg_valid/ready      cfg_index (3b), cfg_data (17b)
//
// A tick runs from acceptance to its last pixel being loaded in this order:
// each knob in turn through the one shared knob update unit (delta and weight
// multiply, accumulate and clamp, move/fade/decay), each LED through the
// two-stage LED color pipeline, then the 22 pixels at one pixel per cycle
// while the output register is free; pixel stalls hold the sequence. A new
// tick is taken only after the last pixel is loaded. The next tick is taken
// while the last pixel still sits in the output register. Reset (arst_n low)
// restores control, config and knob state; config writes are taken at any time.

module knob_led_chase_effect (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               tick_valid,
	output logic                    tick_stall,
	input  wire kle_pkg::tick_t     tick,

	output logic                    pix_valid,
	input  wire logic               pix_stall,
	output kle_pkg::pixel_t         pix,

	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [16:0]        cfg_data
);

	kle_pkg::ctrl_cmd_t   cmd;
	kle_pkg::ctrl_sts_t   sts;
	kle_pkg::cfg_wr_t     cfg;
	kle_pkg::pos_t        pos    [kle_pkg::KNOBS];
	kle_pkg::bright_t     bright [kle_pkg::KNOBS];

	// registers are always writable; each accepted transaction is written straight into its register
	assign cfg_ready = 1'b1;
	assign cfg.write = cfg_valid && cfg_ready;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// sequence: capture, per knob update, LED colors, pixel send
	kle_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// velocity, spot position, brightness and idle counters
	kle_knob u_knob (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.tick   (tick),
		.pos    (pos),
		.bright (bright)
	);

	// color mixing, button overrides and output register
	kle_pixel u_pixel (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.tick      (tick),
		.pos       (pos),
		.bright    (bright),
		.sts       (sts),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix)
	);

	// a taken tick keeps the block busy for the next cycle
	a_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && !tick_stall |=> tick_stall)
		else $error("tick taken while previous tick still in work");

	// frame marker sits on the final slot only
	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> (pix.last_pixel == (pix.chain_slot == kle_pkg::LAST_SLOT)))
		else $error("last_pixel and chain_slot disagree");

	// pixels of a frame follow in slot order
	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall && !pix.last_pixel ##1 pix_valid
		|-> pix.chain_slot == $past(pix.chain_slot) + 5'd1)
		else $error("pixel slot out of order");

endmodule

`default_nettype wire
